### rtl/next_fit_page_frame_allocator_top_macros.svh
// Assertion macros for the next-fit page frame allocator.
`ifndef NEXT_FIT_PAGE_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define NEXT_FIT_PAGE_FRAME_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define NFPFA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nfpfa assertion failed");

// Next-cycle implication, disabled in reset.
`define NFPFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nfpfa assertion failed");

`endif

### rtl/nfpfa_pkg.sv
// Shared field widths, request codes and result status codes of the page frame allocator.
`timescale 1ns / 1ps

package nfpfa_pkg;

  localparam int PID_W    = 4;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 3;
  localparam int FRAME_W  = 5;
  localparam int COUNT_W  = 6;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC     = 3'd0,
    ST_FREED     = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_FRAMES = 3'd3,
    ST_ZERO      = 3'd4
  } status_t;

endpackage

### rtl/nfpfa_req_if.sv
// Request channel: allocate or free, with owner and size.
`timescale 1ns / 1ps

interface nfpfa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [nfpfa_pkg::PID_W-1:0]  proc_id;
  logic [nfpfa_pkg::SIZE_W-1:0] size_kb;

  modport source (output valid, req_type, proc_id, size_kb, input ready);
  modport sink   (input valid, req_type, proc_id, size_kb, output ready);
endinterface

### rtl/nfpfa_rsp_if.sv
// Result channel: one transfer per allocated run or per status report.
`timescale 1ns / 1ps

interface nfpfa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [nfpfa_pkg::STATUS_W-1:0] status;
  logic [nfpfa_pkg::FRAME_W-1:0]  run_start;
  logic [nfpfa_pkg::FRAME_W-1:0]  run_end;
  logic [nfpfa_pkg::COUNT_W-1:0]  frame_count;
  logic [nfpfa_pkg::COUNT_W-1:0]  free_left;
  logic                           last;

  modport source (output valid, status, run_start, run_end, frame_count, free_left, last,
                  input ready);
  modport sink   (input valid, status, run_start, run_end, frame_count, free_left, last,
                  output ready);
endinterface

### rtl/nfpfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module nfpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/next_fit_page_frame_allocator_top.sv
// Top level of the next-fit page frame allocator: control sequencer and frame table.
//
// Usage:
//   req carries one request per transfer: req_type 0 allocates size_kb for proc_id,
//   req_type 1 frees every frame that proc_id owns. rsp returns the results.
//   An allocate gives one transfer per contiguous run of frames it fills, in scan
//   order from the next-fit pointer; the final one has last set. A free, and any
//   rejected allocate (zero size, too large, not enough free frames), gives a
//   single transfer with last set.
//   One request is in work at a time; req.ready is high only while idle.
//   An allocate scans at most FRAMES frames from the next-fit pointer; a free
//   scans the whole table and then reports. The scan rate is set by the frame
//   table RAM: one read-modify-write per frame per cycle while the scan is not held.
//   After reset the table is swept clear, one frame per cycle, so req.ready
//   stays low until the sweep is done.
//   Results sit in an output register; when it is full with rsp.ready low and
//   a new run must go out, the scan holds on the current frame until it drains.
`timescale 1ns / 1ps
`include "next_fit_page_frame_allocator_top_macros.svh"

module next_fit_page_frame_allocator_top #(
  parameter int FRAMES   = 32,
  parameter int FRAME_KB = 4
) (
  input  logic        clk,
  input  logic        rst,
  nfpfa_req_if.sink   req,
  nfpfa_rsp_if.source rsp
);

  localparam int IDXW = $clog2(FRAMES);
  localparam int CNTW = $clog2(FRAMES + 1);
  localparam int KBW  = $clog2(FRAMES * FRAME_KB + 1);
  localparam int CW   = nfpfa_pkg::SIZE_W + 1;
  localparam int PW   = nfpfa_pkg::PID_W;
  localparam int EW   = 1 + PW + IDXW;

  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(FRAMES - 1);
  localparam logic [CW-1:0]   TOTAL_KB = CW'(FRAMES * FRAME_KB);
  localparam logic [KBW-1:0]  PAGE_KB  = KBW'(FRAME_KB);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_ALLOC, S_FREE, S_REPORT} state_t;

  state_t                  state;
  logic [IDXW-1:0]         scan;
  logic [IDXW-1:0]         next_fit_ptr;
  logic [CNTW-1:0]         free_frames;
  logic [PW-1:0]           pid;
  logic [KBW-1:0]          rem;
  logic [IDXW-1:0]         page_idx;
  logic                    in_run;
  logic [IDXW-1:0]         rstart;
  logic [CNTW-1:0]         rcount;
  logic [CNTW-1:0]         fcnt;
  nfpfa_pkg::status_t      rep_status;
  logic [CNTW-1:0]         rep_count;

  logic                                out_valid;
  logic [nfpfa_pkg::STATUS_W-1:0]      out_status;
  logic [nfpfa_pkg::FRAME_W-1:0]       out_start;
  logic [nfpfa_pkg::FRAME_W-1:0]       out_end;
  logic [nfpfa_pkg::COUNT_W-1:0]       out_count;
  logic [nfpfa_pkg::COUNT_W-1:0]       out_free;
  logic                                out_last;

  logic            wr_en;
  logic [IDXW-1:0] wr_addr;
  logic [EW-1:0]   wr_data;
  logic [IDXW-1:0] rd_addr;
  logic [EW-1:0]   rd_data;

  logic            ent_used;
  logic [PW-1:0]   ent_owner;
  logic            owner_hit;
  logic            last_frame;
  logic            emit_ok;
  logic            alloc_emit;
  logic            stall;
  logic            load_out;
  logic [IDXW-1:0] scan_inc;
  logic [IDXW-1:0] scan_dec;
  logic [CNTW-1:0] run_base;
  logic [CW-1:0]   free_kb;
  logic [CW-1:0]   size_ext;

  nfpfa_ram #(
    .WIDTH(EW),
    .DEPTH(FRAMES)
  ) u_frame_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign ent_used   = rd_data[EW-1];
  assign ent_owner  = rd_data[EW-2 -: PW];
  assign owner_hit  = ent_used && (ent_owner == pid);
  assign last_frame = (rem <= PAGE_KB);
  assign emit_ok    = !out_valid || rsp.ready;
  assign alloc_emit = (state == S_ALLOC) && (ent_used ? in_run : last_frame);
  assign stall      = alloc_emit && !emit_ok;
  assign load_out   = (state == S_ALLOC) ? (alloc_emit && emit_ok)
                                         : ((state == S_REPORT) && emit_ok);
  assign scan_inc   = (scan == LAST_IDX) ? '0 : scan + 1'b1;
  assign scan_dec   = (scan == '0) ? LAST_IDX : scan - 1'b1;
  assign run_base   = in_run ? rcount : '0;
  assign free_kb    = CW'(free_frames) * CW'(FRAME_KB);
  assign size_ext   = CW'(req.size_kb);

  assign req.ready  = (state == S_IDLE);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = scan;
    wr_data = '0;
    rd_addr = scan;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        rd_addr = (req.req_type == nfpfa_pkg::REQ_FREE) ? '0 : next_fit_ptr;
      end
      S_ALLOC: begin
        wr_en   = !ent_used && !stall;
        wr_data = {1'b1, pid, page_idx};
        rd_addr = stall ? scan : scan_inc;
      end
      S_FREE: begin
        wr_en   = owner_hit;
        rd_addr = scan_inc;
      end
      S_REPORT: begin
        rd_addr = scan;
      end
      default: begin
        rd_addr = scan;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      scan         <= '0;
      next_fit_ptr <= '0;
      free_frames  <= CNTW'(FRAMES);
      in_run       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          scan <= scan_inc;
          if (scan == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            pid      <= req.proc_id;
            rem      <= KBW'(req.size_kb);
            page_idx <= '0;
            in_run   <= 1'b0;
            fcnt     <= '0;
            rep_count <= '0;
            if (req.req_type == nfpfa_pkg::REQ_FREE) begin
              scan  <= '0;
              state <= S_FREE;
            end else if (req.size_kb == '0) begin
              rep_status <= nfpfa_pkg::ST_ZERO;
              state      <= S_REPORT;
            end else if (size_ext > TOTAL_KB) begin
              rep_status <= nfpfa_pkg::ST_TOO_LARGE;
              state      <= S_REPORT;
            end else if (size_ext > free_kb) begin
              rep_status <= nfpfa_pkg::ST_NO_FRAMES;
              state      <= S_REPORT;
            end else begin
              scan  <= next_fit_ptr;
              state <= S_ALLOC;
            end
          end
        end
        S_ALLOC: begin
          if (!stall) begin
            scan <= scan_inc;
            if (!ent_used) begin
              page_idx    <= page_idx + 1'b1;
              free_frames <= free_frames - 1'b1;
              rcount      <= run_base + 1'b1;
              if (!in_run) begin
                rstart <= scan;
              end
              if (last_frame) begin
                out_status   <= nfpfa_pkg::ST_ALLOC;
                out_start    <= nfpfa_pkg::FRAME_W'(in_run ? rstart : scan);
                out_end      <= nfpfa_pkg::FRAME_W'(scan);
                out_count    <= nfpfa_pkg::COUNT_W'(run_base + 1'b1);
                out_free     <= nfpfa_pkg::COUNT_W'(free_frames - 1'b1);
                out_last     <= 1'b1;
                in_run       <= 1'b0;
                next_fit_ptr <= scan_inc;
                state        <= S_IDLE;
              end else begin
                rem    <= rem - PAGE_KB;
                in_run <= 1'b1;
              end
            end else if (in_run) begin
              out_status <= nfpfa_pkg::ST_ALLOC;
              out_start  <= nfpfa_pkg::FRAME_W'(rstart);
              out_end    <= nfpfa_pkg::FRAME_W'(scan_dec);
              out_count  <= nfpfa_pkg::COUNT_W'(rcount);
              out_free   <= nfpfa_pkg::COUNT_W'(free_frames);
              out_last   <= 1'b0;
              in_run     <= 1'b0;
            end
          end
        end
        S_FREE: begin
          scan <= scan_inc;
          if (owner_hit) begin
            fcnt        <= fcnt + 1'b1;
            free_frames <= free_frames + 1'b1;
          end
          if (scan == LAST_IDX) begin
            rep_status <= nfpfa_pkg::ST_FREED;
            rep_count  <= owner_hit ? fcnt + 1'b1 : fcnt;
            state      <= S_REPORT;
          end
        end
        S_REPORT: begin
          if (emit_ok) begin
            out_status <= rep_status;
            out_start  <= '0;
            out_end    <= '0;
            out_count  <= nfpfa_pkg::COUNT_W'(rep_count);
            out_free   <= nfpfa_pkg::COUNT_W'(free_frames);
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.run_start   = out_start;
  assign rsp.run_end     = out_end;
  assign rsp.frame_count = out_count;
  assign rsp.free_left   = out_free;
  assign rsp.last        = out_last;

  `NFPFA_ASSERT_IMPL(a_free_bound, clk, rst, 1'b1, free_frames <= CNTW'(FRAMES))
  `NFPFA_ASSERT_IMPL(a_mid_run_alloc, clk, rst, rsp.valid && !rsp.last, rsp.status == nfpfa_pkg::ST_ALLOC)
  `NFPFA_ASSERT_IMPL(a_no_write_idle, clk, rst, state == S_IDLE || state == S_REPORT, !wr_en)
  `NFPFA_ASSERT_NEXT(a_free_report, clk, rst, state == S_FREE && scan == LAST_IDX, state == S_REPORT)

endmodule
